FILE: rtl/running_median_filter_assert.svh
// Assertion macros for the running median filter checker.
// Needs a scope that has i_clk and i_rst_n (active low, synchronous).
`ifndef RUNNING_MEDIAN_FILTER_ASSERT_SVH
`define RUNNING_MEDIAN_FILTER_ASSERT_SVH

// Check a property at every clock edge outside reset.
`define RMF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property at every clock edge, reset included.
`define RMF_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: rtl/rmf_pkg.sv
// Shared types and constants of the running median filter.
// No dependencies; used by the cell and top level.
package rmf_pkg;

    // Width of the window length register on the configuration port.
    localparam int CFG_BITS  = 5;
    // Legal floor and reset value of the window length.
    localparam int WIN_MIN   = 3;
    localparam int WIN_RESET = 7;

    // Command broadcast from the top level to every cell.
    typedef struct packed {
        logic step;   // insert the new sample, drop the oldest entry
        logic clear;  // zero the window and restore the ring order
    } t_chain_cmd;

    // Status a cell hands to its neighbors.
    typedef struct packed {
        logic gt;        // held value is greater than the new sample
        logic del_seen;  // the oldest entry sits in this cell or further left
    } t_cell_link;

endpackage

FILE: rtl/rmf_sample_if.sv
// Input stream interface of the running median filter: one sample per transfer.
// No dependencies.
interface rmf_sample_if #(
    parameter int SAMPLE_BITS = 16
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

FILE: rtl/rmf_median_if.sv
// Output stream interface of the running median filter: one median per transfer.
// No dependencies.
interface rmf_median_if #(
    parameter int SAMPLE_BITS = 16
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] median;

    modport source (output valid, output median, input ready);
    modport sink   (input valid, input median, output ready);
endinterface

FILE: rtl/rmf_cell.sv
// One cell of the sorted window chain: holds one value and its ring position.
// Depends on rmf_pkg.
module rmf_cell import rmf_pkg::*; #(
    parameter int SAMPLE_BITS = 16,
    parameter int TAG_BITS    = 5,
    parameter int LEN_BITS    = 5,
    parameter int INDEX       = 0
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_chain_cmd             i_cmd,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic [TAG_BITS-1:0]    i_wr_pos,
    input  logic [LEN_BITS-1:0]    i_len,
    input  logic [SAMPLE_BITS-1:0] i_lo_value,
    input  logic [TAG_BITS-1:0]    i_lo_tag,
    input  t_cell_link             i_lo_link,
    input  logic [SAMPLE_BITS-1:0] i_hi_value,
    input  logic [TAG_BITS-1:0]    i_hi_tag,
    input  t_cell_link             i_hi_link,
    output logic [SAMPLE_BITS-1:0] o_value,
    output logic [TAG_BITS-1:0]    o_tag,
    output t_cell_link             o_link
);

    logic [SAMPLE_BITS-1:0] r_value, n_value;
    logic [TAG_BITS-1:0]    r_tag, n_tag;

    logic                   active, last, gt_self, hit, del_here;
    logic [SAMPLE_BITS-1:0] cur_value, prv_value;
    logic [TAG_BITS-1:0]    cur_tag, prv_tag;
    logic                   cur_gt, prv_gt;

    assign active   = LEN_BITS'(INDEX) < i_len;
    assign last     = LEN_BITS'(INDEX + 1) == i_len;
    assign gt_self  = $signed(r_value) > $signed(i_sample);
    assign hit      = active && (r_tag == i_wr_pos);
    assign del_here = i_lo_link.del_seen | hit;

    // Entry at this place and at the place to the left once the oldest entry is dropped.
    // The last active place counts as greater than any sample.
    assign cur_value = del_here ? i_hi_value : r_value;
    assign cur_tag   = del_here ? i_hi_tag : r_tag;
    assign cur_gt    = last | (del_here ? i_hi_link.gt : gt_self);
    assign prv_value = i_lo_link.del_seen ? r_value : i_lo_value;
    assign prv_tag   = i_lo_link.del_seen ? r_tag : i_lo_tag;
    assign prv_gt    = i_lo_link.del_seen ? gt_self : i_lo_link.gt;

    always_comb begin
        if (!cur_gt) begin
            n_value = cur_value;
            n_tag   = cur_tag;
        end else if (prv_gt) begin
            n_value = prv_value;
            n_tag   = prv_tag;
        end else begin
            n_value = i_sample;
            n_tag   = i_wr_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_value <= '0;
            r_tag   <= TAG_BITS'(INDEX);
        end else if (i_cmd.step && active) begin
            r_value <= n_value;
            r_tag   <= n_tag;
        end
    end

    assign o_value         = r_value;
    assign o_tag           = r_tag;
    assign o_link.gt       = gt_self;
    assign o_link.del_seen = del_here;

endmodule

FILE: rtl/rmf_median_sel.sv
// Picks the middle pair of the sorted chain and averages it with floor rounding.
// No package dependencies.
module rmf_median_sel #(
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_WINDOW  = 31,
    parameter int LEN_BITS    = 5
) (
    input  logic [SAMPLE_BITS-1:0] i_values [MAX_WINDOW],
    input  logic [LEN_BITS-1:0]    i_len,
    output logic [SAMPLE_BITS-1:0] o_median
);

    logic [LEN_BITS-1:0]  mid_idx, lo_idx;
    logic [SAMPLE_BITS-1:0] hi_val, lo_val;
    logic [SAMPLE_BITS:0]   pair_sum;

    // Odd length: both picks land on the middle cell, so the average is that value.
    assign mid_idx = i_len >> 1;
    assign lo_idx  = i_len[0] ? mid_idx : mid_idx - LEN_BITS'(1);

    always_comb begin
        hi_val = '0;
        lo_val = '0;
        for (int k = 0; k < MAX_WINDOW; k++) begin
            if (LEN_BITS'(k) == mid_idx) hi_val |= i_values[k];
            if (LEN_BITS'(k) == lo_idx)  lo_val |= i_values[k];
        end
    end

    assign pair_sum = {hi_val[SAMPLE_BITS-1], hi_val} + {lo_val[SAMPLE_BITS-1], lo_val};
    assign o_median = pair_sum[SAMPLE_BITS:1];

endmodule

FILE: rtl/running_median_filter.sv
// Running median filter. Each sample transfer overwrites the oldest of the
// last window_length samples (3..MAX_WINDOW, reset 7; writes outside that
// range saturate) and yields one median transfer: the middle value for an
// odd length, the floor of the middle pair's average for an even length.
// The window starts as zeros and those zeros count until overwritten;
// writing window_length zeros the window again. The window lives in a row
// of MAX_WINDOW cells kept in sorted order; each cell keeps one value and
// its ring position, and on every sample all active cells update together
// from their neighbors, dropping the oldest entry and slotting the new one
// in. The block takes one sample per clock while medians are accepted;
// a median passes through the cell update and then the median pick into
// the output register. A stalled output holds one median and one more
// sample in the cells, after which input ready drops. Write window_length
// only while no median is outstanding.
// Depends on rmf_pkg, rmf_sample_if, rmf_median_if, rmf_cell, rmf_median_sel.
module running_median_filter import rmf_pkg::*; #(
    parameter int MAX_WINDOW  = 31,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    rmf_sample_if.sink          i_sample_ch,
    rmf_median_if.source        o_median_ch,
    input  logic                i_cfg_wr_en,
    input  logic [CFG_BITS-1:0] i_cfg_wr_data
);

    localparam int TAG_BITS = $clog2(MAX_WINDOW);
    localparam int LEN_BITS = $clog2(MAX_WINDOW + 1);
    localparam int LenReset = (WIN_RESET > MAX_WINDOW) ? MAX_WINDOW : WIN_RESET;

    // Window length and ring write position.
    logic [LEN_BITS-1:0] r_len, n_len;
    logic [TAG_BITS-1:0] r_wr_pos, n_wr_pos;

    // Output stage: r_pend marks cells holding a median not yet picked.
    logic                   r_pend, n_pend;
    logic                   r_out_valid, n_out_valid;
    logic [SAMPLE_BITS-1:0] r_median;

    logic                   in_ready, in_xfer, load_out;
    logic [SAMPLE_BITS-1:0] w_median;
    t_chain_cmd             chain_cmd;

    logic [SAMPLE_BITS-1:0] w_value [MAX_WINDOW];
    logic [TAG_BITS-1:0]    w_tag   [MAX_WINDOW];
    t_cell_link             w_link  [MAX_WINDOW];

    // Load the output register when a median waits and the slot is free or leaving.
    assign load_out = r_pend && (!r_out_valid || o_median_ch.ready);
    assign in_ready = i_rst_n && (!r_pend || load_out);
    assign in_xfer  = i_sample_ch.valid && in_ready;

    assign chain_cmd.step  = in_xfer;
    assign chain_cmd.clear = i_cfg_wr_en;

    // Saturate the written length into the legal range.
    always_comb begin
        if (int'(i_cfg_wr_data) < WIN_MIN) begin
            n_len = LEN_BITS'(WIN_MIN);
        end else if (int'(i_cfg_wr_data) > MAX_WINDOW) begin
            n_len = LEN_BITS'(MAX_WINDOW);
        end else begin
            n_len = LEN_BITS'(i_cfg_wr_data);
        end
    end

    // Advance the ring position, wrapping after the last active entry.
    always_comb begin
        if (LEN_BITS'(r_wr_pos) + LEN_BITS'(1) == r_len) begin
            n_wr_pos = '0;
        end else begin
            n_wr_pos = r_wr_pos + TAG_BITS'(1);
        end
    end

    assign n_pend      = in_xfer || (r_pend && !load_out);
    assign n_out_valid = load_out || (r_out_valid && !o_median_ch.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= LEN_BITS'(LenReset);
            r_wr_pos    <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_len    <= n_len;
                r_wr_pos <= '0;
            end else if (in_xfer) begin
                r_wr_pos <= n_wr_pos;
            end
        end
    end

    // Median payload: hold while stalled.
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_median <= w_median;
        end
    end

    // Sorted cell row; the ends see a neutral neighbor.
    for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
        logic [SAMPLE_BITS-1:0] lo_value, hi_value;
        logic [TAG_BITS-1:0]    lo_tag, hi_tag;
        t_cell_link             lo_link, hi_link;

        if (k == 0) begin : g_first
            assign lo_value = '0;
            assign lo_tag   = '0;
            assign lo_link  = '0;
        end else begin : g_inner_lo
            assign lo_value = w_value[k-1];
            assign lo_tag   = w_tag[k-1];
            assign lo_link  = w_link[k-1];
        end

        if (k == MAX_WINDOW - 1) begin : g_last
            assign hi_value = '0;
            assign hi_tag   = '0;
            assign hi_link  = '0;
        end else begin : g_inner_hi
            assign hi_value = w_value[k+1];
            assign hi_tag   = w_tag[k+1];
            assign hi_link  = w_link[k+1];
        end

        rmf_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .TAG_BITS    (TAG_BITS),
            .LEN_BITS    (LEN_BITS),
            .INDEX       (k)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmd      (chain_cmd),
            .i_sample   (i_sample_ch.sample),
            .i_wr_pos   (r_wr_pos),
            .i_len      (r_len),
            .i_lo_value (lo_value),
            .i_lo_tag   (lo_tag),
            .i_lo_link  (lo_link),
            .i_hi_value (hi_value),
            .i_hi_tag   (hi_tag),
            .i_hi_link  (hi_link),
            .o_value    (w_value[k]),
            .o_tag      (w_tag[k]),
            .o_link     (w_link[k])
        );
    end

    rmf_median_sel #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_WINDOW  (MAX_WINDOW),
        .LEN_BITS    (LEN_BITS)
    ) u_median_sel (
        .i_values (w_value),
        .i_len    (r_len),
        .o_median (w_median)
    );

    assign i_sample_ch.ready  = in_ready;
    assign o_median_ch.valid  = r_out_valid;
    assign o_median_ch.median = r_median;

endmodule

FILE: rtl/rmf_checker.sv
// Port-level checks of the running median filter, bound to the top level.
// Depends on running_median_filter_assert.svh.
`include "running_median_filter_assert.svh"

module rmf_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   i_in_ready,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic [SAMPLE_BITS-1:0] i_out_median
);

    // A stalled median stays offered and unchanged.
    `RMF_ASSERT(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid, "median dropped while stalled")
    `RMF_ASSERT(a_out_stable, i_out_valid && !i_out_ready |=> $stable(i_out_median), "median changed while stalled")

    // An empty output stage never back-pressures the input.
    `RMF_ASSERT(a_ready_when_empty, !i_out_valid |-> i_in_ready, "input stalled with empty output")

    // A fresh median follows a sample transfer through the cell update and the output register.
    `RMF_ASSERT(a_median_source, $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 2), "median without sample")

    // Reset empties the output.
    `RMF_ASSERT_ALWAYS(a_reset_empty, $past(!i_rst_n) |-> !i_out_valid, "median offered after reset")

endmodule

bind running_median_filter rmf_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_rmf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_sample_ch.valid),
    .i_in_ready   (i_sample_ch.ready),
    .i_out_valid  (o_median_ch.valid),
    .i_out_ready  (o_median_ch.ready),
    .i_out_median (o_median_ch.median)
);
